// ----- rtl/lge_pkg.sv -----
// Shared constants and types for the life grid generation engine.
package lge_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Configuration register indexes and port geometry.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam int   APB_ADDR_W      = 3;
  localparam int   APB_DATA_W      = 32;
  localparam int   CFG_W           = 9;
  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // Life rule: birth on three live neighbors, survival on two or three.
  localparam logic [3:0] NB_BIRTH   = 4'd3;
  localparam logic [3:0] NB_SURVIVE = 4'd2;

  // 3x3 neighborhood of one cell; bit 2 is the left column, bit 0 the right.
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] center;
    logic [2:0] below;
    logic       left_ok;
    logic       right_ok;
    logic       in_region;
  } window_t;

endpackage

// ----- rtl/lge_row_mem.sv -----
// Row-wide grid memory: one write port, one registered read port.
module lge_row_mem #(
  parameter int ROWS  = 256,
  parameter int ROW_W = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(ROWS)-1:0]  waddr,
  input  logic [ROW_W-1:0]         wdata,
  input  logic [$clog2(ROWS)-1:0]  raddr,
  output logic [ROW_W-1:0]         rdata
);

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lge_cell_rule.sv -----
// Shared cell evaluator: counts live neighbors and applies the B3/S23 rule.
module lge_cell_rule (
  input  lge_pkg::window_t win,
  output logic             next_alive
);
  import lge_pkg::*;

  logic [7:0] nb;
  logic [3:0] count;

  always_comb begin
    nb = {win.above[2]  & win.left_ok, win.above[1],  win.above[0]  & win.right_ok,
          win.center[2] & win.left_ok,                win.center[0] & win.right_ok,
          win.below[2]  & win.left_ok, win.below[1],  win.below[0]  & win.right_ok};
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(nb[i]);
    end
    next_alive = win.in_region &&
                 ((count == NB_BIRTH) || (win.center[1] && (count == NB_SURVIVE)));
  end

endmodule

// ----- rtl/lge_apb_regs.sv -----
// APB register file holding the grid width and height.
module lge_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lge_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lge_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lge_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [lge_pkg::CFG_W-1:0]        grid_width,
  output logic [lge_pkg::CFG_W-1:0]        grid_height
);
  import lge_pkg::*;

  logic reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_RESET;
      grid_height <= SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height);
    endcase
  end

endmodule

// ----- rtl/life_grid_generation_engine.sv -----
// Top level of the life grid generation engine: sequencer, row window and grid memory.
//
// This block keeps a grid of MAX_WIDTH by MAX_HEIGHT cells, of which grid_width columns
// by grid_height rows are in use (register values are clamped to 1..MAX), and runs
// Conway's B3/S23 rule on it with dead cells beyond the edges and no wrap. The grid is
// stored one row per memory word. After reset the block stalls its item channel while
// it clears the memory one row per cycle; configuration writes are taken at any time.
// One transaction is processed at a time: a cell write reads the row and then writes
// it back, a cell read reads the row and offers its result from the emit state, and
// a generation step loads the first rows and then works through the grid row by row.
// The step is paced by the single cell evaluator, which handles one cell per cycle,
// and by a write-back of the new row at each row end. The step always sweeps the whole
// stored grid, so cells outside the region in use come out dead. Three row registers
// hold the rows above, at and below the current row and rotate by one cell per cycle,
// so the evaluator always sees its neighborhood at fixed taps; the next row down is
// fetched while the last cell of a row is evaluated, and each new row is written back
// only once the old row is no longer needed, so no second grid is stored. A result
// waits in an output register, and the next transaction can be accepted while it
// waits.
module life_grid_generation_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  // Item channel.
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       opcode,
  input  logic [7:0]                       cell_x,
  input  logic [7:0]                       cell_y,
  input  logic                             write_alive,
  // Result channel.
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             read_alive,
  output logic                             generation_done,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lge_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lge_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lge_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import lge_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = XW + 1;
  localparam int HW = YW + 1;
  localparam logic [XW-1:0] COL_LAST = XW'(MAX_WIDTH - 1);
  localparam logic [YW-1:0] ROW_LAST = YW'(MAX_HEIGHT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_RMW,
    ST_LOAD0,
    ST_LOAD1,
    ST_LOAD2,
    ST_CELL,
    ST_ROW_WB,
    ST_EMIT
  } state_t;

  state_t state;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;

  // Latched item and pending result.
  logic [1:0] op_q;
  logic [7:0] x_q;
  logic [7:0] y_q;
  logic       v_q;
  logic       pend_alive;
  logic       pend_done;

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [HW-1:0] row_plus2;

  logic [MAX_WIDTH-1:0] row_above;
  logic [MAX_WIDTH-1:0] row_center;
  logic [MAX_WIDTH-1:0] row_below;
  logic [MAX_WIDTH-1:0] row_new;
  logic [MAX_WIDTH-1:0] row_mod;

  logic                 mem_we;
  logic [YW-1:0]        mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic [YW-1:0]        mem_raddr;
  logic [MAX_WIDTH-1:0] mem_rdata;

  logic [XW-1:0] x_idx;
  logic          item_in_region;
  window_t       win;
  logic          cell_next;

  lge_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_width  (grid_width),
    .grid_height (grid_height)
  );

  lge_row_mem #(
    .ROWS  (MAX_HEIGHT),
    .ROW_W (MAX_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lge_cell_rule u_rule (
    .win        (win),
    .next_alive (cell_next)
  );

  // Clamp the size registers to the stored grid.
  always_comb begin
    if (grid_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height);
    end
  end

  assign item_stall     = (state != ST_IDLE);
  assign x_idx          = XW'(x_q);
  assign item_in_region = (32'(x_q) < 32'(eff_w)) && (32'(y_q) < 32'(eff_h));
  assign row_plus2      = HW'(row) + HW'(2);

  // Neighborhood at the fixed taps of the rotating row registers.
  always_comb begin
    win.above     = {row_above[MAX_WIDTH-1],  row_above[0],  row_above[1]};
    win.center    = {row_center[MAX_WIDTH-1], row_center[0], row_center[1]};
    win.below     = {row_below[MAX_WIDTH-1],  row_below[0],  row_below[1]};
    win.left_ok   = (col != '0);
    win.right_ok  = ((WW'(col) + WW'(1)) < eff_w);
    win.in_region = (WW'(col) < eff_w) && (HW'(row) < eff_h);
  end

  // Row image for a cell write.
  always_comb begin
    row_mod        = mem_rdata;
    row_mod[x_idx] = v_q;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row;
    mem_wdata = row_new;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_RMW: begin
        mem_we    = (op_q == OP_WRITE) && item_in_region;
        mem_waddr = YW'(y_q);
        mem_wdata = row_mod;
      end
      ST_ROW_WB: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state)
      ST_ACCESS: mem_raddr = YW'(y_q);
      ST_LOAD0:  mem_raddr = '0;
      ST_LOAD1:  mem_raddr = YW'(1);
      ST_CELL:   mem_raddr = row_plus2[YW-1:0];
      default:   mem_raddr = row;
    endcase
  end

  // Row window: rotate one cell per cycle, slide down one row at each row end.
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD1: begin
        row_center <= mem_rdata;
      end
      ST_LOAD2: begin
        row_above <= '0;
        row_below <= (eff_h > HW'(1)) ? mem_rdata : '0;
      end
      ST_CELL: begin
        row_above  <= {row_above[0],  row_above[MAX_WIDTH-1:1]};
        row_center <= {row_center[0], row_center[MAX_WIDTH-1:1]};
        row_below  <= {row_below[0],  row_below[MAX_WIDTH-1:1]};
        row_new    <= {cell_next,     row_new[MAX_WIDTH-1:1]};
      end
      ST_ROW_WB: begin
        row_above  <= row_center;
        row_center <= row_below;
        row_below  <= (row_plus2 < eff_h) ? mem_rdata : '0;
      end
      default: ;
    endcase
  end

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      row          <= '0;
      col          <= '0;
      result_valid <= 1'b0;
    end else begin
      // The emit state handles the result register itself.
      if (result_valid && !result_stall && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (row == ROW_LAST) begin
            row   <= '0;
            state <= ST_IDLE;
          end else begin
            row <= row + YW'(1);
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            op_q <= opcode;
            x_q  <= cell_x;
            y_q  <= cell_y;
            v_q  <= write_alive;
            case (opcode) inside
              OP_WRITE, OP_READ: state <= ST_ACCESS;
              OP_STEP:           state <= ST_LOAD0;
              default:           state <= ST_IDLE;
            endcase
          end
        end
        ST_ACCESS: begin
          state <= ST_RMW;
        end
        ST_RMW: begin
          if (op_q == OP_READ) begin
            pend_alive <= item_in_region & mem_rdata[x_idx];
            pend_done  <= 1'b0;
            state      <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_LOAD0: begin
          state <= ST_LOAD1;
        end
        ST_LOAD1: begin
          state <= ST_LOAD2;
        end
        ST_LOAD2: begin
          row   <= '0;
          col   <= '0;
          state <= ST_CELL;
        end
        ST_CELL: begin
          if (col == COL_LAST) begin
            col   <= '0;
            state <= ST_ROW_WB;
          end else begin
            col <= col + XW'(1);
          end
        end
        ST_ROW_WB: begin
          if (row == ROW_LAST) begin
            row        <= '0;
            pend_alive <= 1'b0;
            pend_done  <= 1'b1;
            state      <= ST_EMIT;
          end else begin
            row   <= row + YW'(1);
            state <= ST_CELL;
          end
        end
        ST_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid    <= 1'b1;
            read_alive      <= pend_alive;
            generation_done <= pend_done;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The grid memory is written only by the clear pass, a cell write or a row write-back.
  a_mem_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_RMW || state == ST_ROW_WB))
    else $error("grid memory written outside a write state");

  // The row registers have rotated a full turn when a row is written back.
  a_row_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW_WB) |-> (col == '0))
    else $error("row write-back with the window out of alignment");

  // A result is either a cell read or the end of a step, never both.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(read_alive && generation_done))
    else $error("result marks both a live read and a finished step");

  // A new result only comes out of the emit state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside the emit state");
`endif

endmodule
